@@ sv/mme_pkg.sv @@
// ---------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helpers for the matrix multiply engine.
// ---------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

    // Largest matrix dimension and fixed-point scaling.
    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;

    // Field widths fixed by the item formats.
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;

    // Element stores.
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // A sum of MAX_DIM full products needs three guard bits at most.
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int SH_W        = ACC_W - FRAC_BITS;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // Input item.
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [VAL_W-1:0] product_value;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic                    saturated;
        logic                    last;
    } t_out_item;

    // Control that travels alongside the store read data into the MAC.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    // A dimension register of zero acts as one, above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val);
        logic [DIM_W-1:0] res;
        if (reg_val == '0) begin
            res = DIM_W'(1);
        end else if (int'(reg_val) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = reg_val;
        end
        return res;
    endfunction

    // Store address of an element, row-major with a stride of MAX_DIM.
    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        logic [ADDR_W+IDX_W:0] full;
        full = (ADDR_W+IDX_W+1)'(row) * (ADDR_W+IDX_W+1)'(MAX_DIM)
             + (ADDR_W+IDX_W+1)'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/mme_ram.sv @@
// ---------------------------------------------------------------------------
// mme_ram
// One matrix element store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mme_ram
    import mme_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire  [ADDR_W-1:0]       i_waddr,
    input  wire  [VAL_W-1:0]        i_wdata,
    input  wire  [ADDR_W-1:0]       i_raddr,
    output logic [VAL_W-1:0]        o_rdata
);

    logic [VAL_W-1:0] mem [STORE_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/mme_mac.sv @@
// ---------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate datapath: registered product, wide accumulator, and
// the fixed-point shift with saturation of the finished sum.
// ---------------------------------------------------------------------------
`default_nettype none

module mme_mac
    import mme_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  t_mac_ctl          i_ctl,
    input  wire  [VAL_W-1:0]        i_a,
    input  wire  [VAL_W-1:0]        i_b,
    input  wire                     i_take,
    output logic                    o_done,
    output logic [VAL_W-1:0]        o_value,
    output logic                    o_sat
);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_pctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [SH_W-1:0]   shifted;
    logic                     all_zero;
    logic                     all_one;

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'($signed(i_a)) * PROD_W'($signed(i_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
        end else begin
            r_pctl <= i_ctl;
        end
    end

    // Accumulate stage; the first product of an element restarts the sum.
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_pctl.vld) begin
            if (r_pctl.first) begin
                r_acc <= prod_ext;
            end else begin
                r_acc <= r_acc + prod_ext;
            end
        end
    end

    // The sum is complete once its last product has been added.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (r_pctl.vld && r_pctl.last) begin
            r_done <= 1'b1;
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    // Arithmetic shift by the fraction bits, then clip to 32 bits.
    assign shifted  = r_acc[ACC_W-1:FRAC_BITS];
    assign all_zero = (shifted[SH_W-1:VAL_W-1] == '0);
    assign all_one  = (shifted[SH_W-1:VAL_W-1] == '1);

    always_comb begin
        if (all_zero || all_one) begin
            o_value = shifted[VAL_W-1:0];
            o_sat   = 1'b0;
        end else if (shifted[SH_W-1]) begin
            o_value = {1'b1, {(VAL_W-1){1'b0}}};
            o_sat   = 1'b1;
        end else begin
            o_value = {1'b0, {(VAL_W-1){1'b1}}};
            o_sat   = 1'b1;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sv/matrix_multiply_engine_top.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply_engine_top
// General matrix multiply on signed Q16.16 elements held in two stores.
//
//   Channel   Direction  Handshake           Carries
//   in        input      valid / stall       t_in_item (load A, load B, multiply)
//   out       output     valid / stall       t_out_item (one product element)
//   cfg       input      valid / ready       register index and 4-bit value
//
// A load item is accepted while the engine is idle and can be followed by
// another at once. A multiply item holds intake until its last product
// element is finished: each product element streams inner_dim read pairs from
// the two stores through one multiplier, then passes the store read,
// product and accumulate registers. A stall on the output holds the sequencer
// before the next element. Reset is synchronous and clears the control
// state and sets every dimension register to 8; the stores are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_top
    import mme_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Input items
    input  wire                     i_in_valid,
    input  wire  t_in_item          i_in_data,
    output logic                    o_in_stall,
    // Result items
    output logic                    o_out_valid,
    output t_out_item               o_out_data,
    input  wire                     i_out_stall,
    // Configuration writes
    input  wire                     i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [DIM_W-1:0]        i_cfg_data,
    output logic                    o_cfg_ready
);

    // Configuration registers.
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_dim;
    logic [DIM_W-1:0] r_cols_b;
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_n;
    logic [DIM_W-1:0] dim_p;

    // Sequencer.
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] n_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_k;
    t_mac_ctl         issue;
    t_mac_ctl         r_issue;
    logic             take;

    // Output register.
    logic             r_out_vld;
    logic             n_out_vld;
    t_out_item        r_out;
    logic             out_free;

    // Store ports.
    logic             in_acc;
    logic             we_a;
    logic             we_b;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [VAL_W-1:0] rdata_a;
    logic [VAL_W-1:0] rdata_b;

    // MAC results.
    logic             mac_done;
    logic [VAL_W-1:0] mac_value;
    logic             mac_sat;
    logic             last_k;
    logic             last_j;
    logic             last_i;

    assign dim_m = eff_dim(r_rows_a);
    assign dim_n = eff_dim(r_inner_dim);
    assign dim_p = eff_dim(r_cols_b);

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(8);
            r_inner_dim <= DIM_W'(8);
            r_cols_b    <= DIM_W'(8);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ROWS_A) begin
                r_rows_a <= i_cfg_data;
            end else if (i_cfg_index == CFG_INNER_DIM) begin
                r_inner_dim <= i_cfg_data;
            end else if (i_cfg_index == CFG_COLS_B) begin
                r_cols_b <= i_cfg_data;
            end
        end
    end

    // Intake is open only while no multiply is in progress.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Loads that fall outside the configured dimensions are dropped.
    assign waddr = addr_of(i_in_data.row_index, i_in_data.col_index);
    assign we_a  = in_acc && (i_in_data.op == OP_LOAD_A)
                 && ({1'b0, i_in_data.row_index} < dim_m)
                 && ({1'b0, i_in_data.col_index} < dim_n);
    assign we_b  = in_acc && (i_in_data.op == OP_LOAD_B)
                 && ({1'b0, i_in_data.row_index} < dim_n)
                 && ({1'b0, i_in_data.col_index} < dim_p);

    // Read addresses of the current inner step.
    assign raddr_a = addr_of(r_i, r_k);
    assign raddr_b = addr_of(r_k, r_j);

    mme_ram u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_in_data.element_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mme_ram u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_in_data.element_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // Issue control is registered to line up with the registered store read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
        end else begin
            r_issue <= issue;
        end
    end

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_issue),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .i_take  (take),
        .o_done  (mac_done),
        .o_value (mac_value),
        .o_sat   (mac_sat)
    );

    assign out_free = !r_out_vld || !i_out_stall;
    assign last_k   = ({1'b0, r_k} == dim_n - DIM_W'(1));
    assign last_j   = ({1'b0, r_j} == dim_p - DIM_W'(1));
    assign last_i   = ({1'b0, r_i} == dim_m - DIM_W'(1));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Next state: walk rows, columns and the inner index.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        issue   = '0;
        take    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.op == OP_MUL)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue.vld   = 1'b1;
                issue.first = (r_k == '0);
                issue.last  = last_k;
                if (last_k) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (mac_done && out_free) begin
                    take = 1'b1;
                    if (last_j && last_i) begin
                        n_state = ST_IDLE;
                    end else if (last_j) begin
                        n_j     = '0;
                        n_i     = r_i + IDX_W'(1);
                        n_state = ST_RUN;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: holds one finished element until it is taken.
    always_comb begin
        n_out_vld = r_out_vld;
        if (take) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.product_value <= mac_value;
            r_out.out_row       <= r_i;
            r_out.out_col       <= r_j;
            r_out.saturated     <= mac_sat;
            r_out.last          <= last_i && last_j;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
